// ----- design/apcs_pkg.sv -----
package apcs_pkg;

  localparam int NUM_SLOTS_DEF = 8;

  localparam logic [2:0] ST_EMPTY = 3'd0;
  localparam logic [2:0] ST_WAIT  = 3'd1;
  localparam logic [2:0] ST_READY = 3'd2;
  localparam logic [2:0] ST_RUN   = 3'd3;
  localparam logic [2:0] ST_IO    = 3'd4;
  localparam logic [2:0] ST_DONE  = 3'd5;

  localparam logic [15:0] PRI_MAX = 16'hffff;

  localparam int IN_DATA_W  = 56;
  localparam int OUT_DATA_W = 80;

  typedef struct packed {
    logic        load;
    logic        age;
    logic        io_inc;
    logic        set_st;
    logic [2:0]  st;
    logic        clr_pri;
    logic        clr_bc;
    logic        clr_ioc;
    logic        set_first;
  } cell_cmd_t;

  typedef struct packed {
    logic [15:0] arrival;
    logic [15:0] total;
    logic [7:0]  burst_len;
    logic [7:0]  io_len;
  } load_data_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] arrival;
    logic [15:0] total;
    logic [15:0] executed;
    logic [7:0]  burst_len;
    logic [7:0]  burst_count;
    logic [7:0]  io_len;
    logic [7:0]  io_count;
    logic [15:0] priority_v;
    logic [16:0] first_run;
  } cell_view_t;

endpackage

// ----- design/aging_priority_cpu_scheduler_core.sv -----
// sequence: a load beat is registered into its slot; a tick beat passes through aging, an
// arrival check of every slot, finish, i/o return, a selection scan of every ready entry
// (skipped when none is ready), dispatch and output states before its result is emitted
// throughput: no new beat is taken while a tick is in progress, longer while out_tready
// is low; one load per cycle while no tick is in progress
// reset: synchronous active-low rst_n empties every slot, the ready list and i/o queue
module aging_priority_cpu_scheduler_core #(
  parameter int NUM_SLOTS = apcs_pkg::NUM_SLOTS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // slot, arrival_time, burst_total, burst_length, io_length
  input  logic [apcs_pkg::IN_DATA_W-1:0]  in_tdata,
  // req_type
  input  logic                            in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // running_valid, running_id, finish_valid, finish_id, turnaround, response,
  // waiting, switch_count, all_done
  output logic [apcs_pkg::OUT_DATA_W-1:0] out_tdata,
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [2:0]                      cfg_paddr,
  input  logic [31:0]                     cfg_pwdata,
  output logic [31:0]                     cfg_prdata,
  output logic                            cfg_pready
);

  localparam int IW = $clog2(NUM_SLOTS);
  localparam int LW = $clog2(NUM_SLOTS + 1);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_AGE    = 3'd1;
  localparam logic [2:0] S_ARRIVE = 3'd2;
  localparam logic [2:0] S_FINISH = 3'd3;
  localparam logic [2:0] S_IORET  = 3'd4;
  localparam logic [2:0] S_SCAN   = 3'd5;
  localparam logic [2:0] S_DISP   = 3'd6;
  localparam logic [2:0] S_EMIT   = 3'd7;

  logic [2:0]    state_r, state_nxt;
  logic [7:0]    ready_step_r, run_step_r;
  logic [15:0]   now_r, now_nxt;
  logic [IW-1:0] ready_q_r [NUM_SLOTS];
  logic [IW-1:0] ready_q_nxt [NUM_SLOTS];
  logic [LW-1:0] rlen_r, rlen_nxt;
  logic [IW-1:0] io_q_r [NUM_SLOTS];
  logic [IW-1:0] io_q_nxt [NUM_SLOTS];
  logic [LW-1:0] iolen_r, iolen_nxt;
  logic          run_valid_r, run_valid_nxt;
  logic [IW-1:0] run_slot_r, run_slot_nxt;
  logic [16:0]   disp_cnt_r, disp_cnt_nxt;
  logic [IW-1:0] idx_r, idx_nxt;
  logic [16:0]   best_pri_r, best_pri_nxt;
  logic [IW-1:0] best_idx_r, best_idx_nxt;
  logic          best_found_r, best_found_nxt;
  logic          fin_r, fin_nxt;
  logic [IW-1:0] fid_r, fid_nxt;
  logic [15:0]   tt_r, tt_nxt;
  logic [15:0]   rt_r, rt_nxt;
  logic [16:0]   wt_r, wt_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [apcs_pkg::OUT_DATA_W-1:0] out_data_r, out_data_nxt;

  apcs_pkg::cell_cmd_t  cmd [NUM_SLOTS];
  apcs_pkg::cell_view_t view [NUM_SLOTS];
  apcs_pkg::load_data_t ld;

  logic          in_acc;
  logic [IW-1:0] in_idx;
  logic          all_done;
  logic [2:0]    in_st;
  logic [IW-1:0] rs, hd, win, e;
  logic [16:0]   p;

  assign ld.arrival   = in_tdata[18:3];
  assign ld.total     = in_tdata[34:19];
  assign ld.burst_len = in_tdata[42:35];
  assign ld.io_len    = in_tdata[50:43];
  assign in_idx       = IW'(in_tdata[2:0]);
  assign in_tready    = (state_r == S_IDLE);
  assign in_acc       = in_tvalid && in_tready;
  assign out_tvalid   = out_valid_r;
  assign out_tdata    = out_data_r;
  assign cfg_pready   = 1'b1;
  assign cfg_prdata   = cfg_paddr[2] ? {24'd0, run_step_r} : {24'd0, ready_step_r};

  genvar gi;
  generate
    for (gi = 0; gi < NUM_SLOTS; gi++) begin : g_cell
      apcs_slot_cell u_cell (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd[gi]),
        .ld         (ld),
        .now_tick   (now_r),
        .ready_step (ready_step_r),
        .run_step   (run_step_r),
        .view       (view[gi])
      );
    end
  endgenerate

  always_comb begin
    all_done = 1'b1;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (view[i].status inside {apcs_pkg::ST_WAIT, apcs_pkg::ST_READY,
                                 apcs_pkg::ST_RUN, apcs_pkg::ST_IO}) begin
        all_done = 1'b0;
      end
    end
  end

  always_comb begin
    state_nxt      = state_r;
    now_nxt        = now_r;
    rlen_nxt       = rlen_r;
    iolen_nxt      = iolen_r;
    run_valid_nxt  = run_valid_r;
    run_slot_nxt   = run_slot_r;
    disp_cnt_nxt   = disp_cnt_r;
    idx_nxt        = idx_r;
    best_pri_nxt   = best_pri_r;
    best_idx_nxt   = best_idx_r;
    best_found_nxt = best_found_r;
    fin_nxt        = fin_r;
    fid_nxt        = fid_r;
    tt_nxt         = tt_r;
    rt_nxt         = rt_r;
    wt_nxt         = wt_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_data_nxt   = out_data_r;
    in_st          = view[in_idx].status;
    rs             = run_slot_r;
    hd             = io_q_r[0];
    win            = ready_q_r[best_idx_r];
    e              = ready_q_r[idx_r];
    p              = {1'b0, view[e].priority_v};
    for (int i = 0; i < NUM_SLOTS; i++) begin
      ready_q_nxt[i] = ready_q_r[i];
      io_q_nxt[i]    = io_q_r[i];
      cmd[i]         = '0;
    end
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (!in_tuser) begin
            if (32'(in_tdata[2:0]) < NUM_SLOTS &&
                !(in_st inside {apcs_pkg::ST_READY, apcs_pkg::ST_RUN, apcs_pkg::ST_IO})) begin
              cmd[in_idx].load = 1'b1;
            end
          end else begin
            state_nxt = S_AGE;
          end
        end
      end
      S_AGE: begin
        for (int i = 0; i < NUM_SLOTS; i++) begin
          cmd[i].age = 1'b1;
        end
        if (iolen_r != '0) begin
          cmd[hd].io_inc = 1'b1;
        end
        fin_nxt   = 1'b0;
        fid_nxt   = '0;
        tt_nxt    = '0;
        rt_nxt    = '0;
        wt_nxt    = '0;
        idx_nxt   = '0;
        state_nxt = S_ARRIVE;
      end
      S_ARRIVE: begin
        if (view[idx_r].status == apcs_pkg::ST_WAIT && view[idx_r].arrival <= now_r) begin
          cmd[idx_r].set_st  = 1'b1;
          cmd[idx_r].st      = apcs_pkg::ST_READY;
          cmd[idx_r].clr_pri = 1'b1;
          ready_q_nxt[rlen_r[IW-1:0]] = idx_r;
          rlen_nxt = rlen_r + LW'(1);
        end
        if (32'(idx_r) == NUM_SLOTS - 1) begin
          state_nxt = S_FINISH;
        end else begin
          idx_nxt = idx_r + IW'(1);
        end
      end
      S_FINISH: begin
        if (run_valid_r) begin
          if (view[rs].executed == view[rs].total) begin
            fin_nxt       = 1'b1;
            fid_nxt       = rs;
            tt_nxt        = now_r - view[rs].arrival;
            rt_nxt        = view[rs].first_run[16] ? 16'd0 : view[rs].first_run[15:0];
            wt_nxt        = {1'b0, tt_nxt} - {1'b0, view[rs].total};
            cmd[rs].set_st = 1'b1;
            cmd[rs].st     = apcs_pkg::ST_DONE;
            run_valid_nxt  = 1'b0;
          end else if (view[rs].burst_count == view[rs].burst_len) begin
            cmd[rs].set_st  = 1'b1;
            cmd[rs].st      = apcs_pkg::ST_IO;
            cmd[rs].clr_bc  = 1'b1;
            cmd[rs].clr_ioc = 1'b1;
            io_q_nxt[iolen_r[IW-1:0]] = rs;
            iolen_nxt      = iolen_r + LW'(1);
            run_valid_nxt  = 1'b0;
          end
        end
        state_nxt = S_IORET;
      end
      S_IORET: begin
        if (iolen_r != '0 && view[hd].io_count == view[hd].io_len) begin
          cmd[hd].set_st  = 1'b1;
          cmd[hd].st      = apcs_pkg::ST_READY;
          cmd[hd].clr_pri = 1'b1;
          cmd[hd].clr_bc  = 1'b1;
          for (int j = 0; j < NUM_SLOTS - 1; j++) begin
            io_q_nxt[j] = io_q_r[(j + 1) % NUM_SLOTS];
          end
          iolen_nxt = iolen_r - LW'(1);
          ready_q_nxt[rlen_r[IW-1:0]] = hd;
          rlen_nxt = rlen_r + LW'(1);
        end
        best_pri_nxt   = run_valid_r ? {1'b0, view[rs].priority_v} : '1;
        best_found_nxt = 1'b0;
        best_idx_nxt   = '0;
        idx_nxt        = '0;
        state_nxt      = (rlen_nxt == '0) ? S_DISP : S_SCAN;
      end
      S_SCAN: begin
        if ($signed(p) > $signed(best_pri_r)) begin
          best_pri_nxt   = p;
          best_idx_nxt   = idx_r;
          best_found_nxt = 1'b1;
        end
        if (LW'(idx_r) + LW'(1) == rlen_r) begin
          state_nxt = S_DISP;
        end else begin
          idx_nxt = idx_r + IW'(1);
        end
      end
      S_DISP: begin
        if (best_found_r) begin
          for (int j = 0; j < NUM_SLOTS; j++) begin
            if (j < NUM_SLOTS - 1 && 32'(best_idx_r) <= j) begin
              ready_q_nxt[j] = ready_q_r[(j + 1) % NUM_SLOTS];
            end
            if (run_valid_r && 32'(rlen_r) - 1 == j) begin
              ready_q_nxt[j] = rs;
            end
          end
          if (run_valid_r) begin
            cmd[rs].set_st = 1'b1;
            cmd[rs].st     = apcs_pkg::ST_READY;
          end else begin
            rlen_nxt = rlen_r - LW'(1);
          end
          cmd[win].set_st    = 1'b1;
          cmd[win].st        = apcs_pkg::ST_RUN;
          cmd[win].set_first = 1'b1;
          run_valid_nxt      = 1'b1;
          run_slot_nxt       = win;
          if ($signed(disp_cnt_r) < $signed(17'd65535)) begin
            disp_cnt_nxt = disp_cnt_r + 17'd1;
          end
        end
        now_nxt   = now_r + 16'd1;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {5'd0, all_done, disp_cnt_r, wt_r, rt_r, tt_r,
                           fin_r ? 3'(fid_r) : 3'd0, fin_r,
                           run_valid_r ? 3'(run_slot_r) : 3'd0, run_valid_r};
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      ready_step_r <= 8'd2;
      run_step_r   <= 8'd1;
      now_r        <= '0;
      rlen_r       <= '0;
      iolen_r      <= '0;
      run_valid_r  <= 1'b0;
      run_slot_r   <= '0;
      disp_cnt_r   <= '1;
      out_valid_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      now_r       <= now_nxt;
      rlen_r      <= rlen_nxt;
      iolen_r     <= iolen_nxt;
      run_valid_r <= run_valid_nxt;
      run_slot_r  <= run_slot_nxt;
      disp_cnt_r  <= disp_cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_psel && cfg_penable && cfg_pwrite) begin
        if (cfg_paddr[2]) begin
          run_step_r <= cfg_pwdata[7:0];
        end else begin
          ready_step_r <= cfg_pwdata[7:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < NUM_SLOTS; i++) begin
      ready_q_r[i] <= ready_q_nxt[i];
      io_q_r[i]    <= io_q_nxt[i];
    end
    idx_r        <= idx_nxt;
    best_pri_r   <= best_pri_nxt;
    best_idx_r   <= best_idx_nxt;
    best_found_r <= best_found_nxt;
    fin_r        <= fin_nxt;
    fid_r        <= fid_nxt;
    tt_r         <= tt_nxt;
    rt_r         <= rt_nxt;
    wt_r         <= wt_nxt;
    out_data_r   <= out_data_nxt;
  end

`ifndef ASSERT_OFF
  a_run_status: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && run_valid_r) |-> (view[run_slot_r].status == apcs_pkg::ST_RUN))
    else $error("running slot not in run status");
  a_queue_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (32'(rlen_r) + 32'(iolen_r) <= NUM_SLOTS))
    else $error("ready and i/o queues overfilled");
  a_tick_start: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_tuser) |=> (state_r == S_AGE))
    else $error("tick beat did not start aging");
`endif

endmodule

// ----- design/apcs_slot_cell.sv -----
module apcs_slot_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  apcs_pkg::cell_cmd_t  cmd,
  input  apcs_pkg::load_data_t ld,
  input  logic [15:0]         now_tick,
  input  logic [7:0]          ready_step,
  input  logic [7:0]          run_step,
  output apcs_pkg::cell_view_t view
);

  logic [2:0]  status_r;
  logic [15:0] arrival_r;
  logic [15:0] total_r;
  logic [15:0] executed_r;
  logic [7:0]  burst_len_r;
  logic [7:0]  burst_count_r;
  logic [7:0]  io_len_r;
  logic [7:0]  io_count_r;
  logic [15:0] pri_r;
  logic [16:0] first_run_r;
  logic [16:0] pri_run_sum;
  logic [16:0] pri_rdy_sum;

  assign pri_run_sum = {1'b0, pri_r} + {9'd0, run_step};
  assign pri_rdy_sum = {1'b0, pri_r} + {9'd0, ready_step};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      arrival_r   <= ld.arrival;
      total_r     <= ld.total;
      burst_len_r <= ld.burst_len;
      io_len_r    <= ld.io_len;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      status_r      <= apcs_pkg::ST_EMPTY;
      executed_r    <= '0;
      burst_count_r <= '0;
      io_count_r    <= '0;
      pri_r         <= '0;
      first_run_r   <= '1;
    end else if (cmd.load) begin
      status_r      <= apcs_pkg::ST_WAIT;
      executed_r    <= '0;
      burst_count_r <= '0;
      io_count_r    <= '0;
      pri_r         <= '0;
      first_run_r   <= '1;
    end else begin
      if (cmd.age) begin
        if (status_r == apcs_pkg::ST_RUN) begin
          pri_r         <= pri_run_sum[16] ? apcs_pkg::PRI_MAX : pri_run_sum[15:0];
          executed_r    <= executed_r + 16'd1;
          burst_count_r <= burst_count_r + 8'd1;
        end
        if (status_r == apcs_pkg::ST_READY) begin
          pri_r <= pri_rdy_sum[16] ? apcs_pkg::PRI_MAX : pri_rdy_sum[15:0];
        end
      end
      if (cmd.io_inc) begin
        io_count_r <= io_count_r + 8'd1;
      end
      if (cmd.set_st) begin
        status_r <= cmd.st;
      end
      if (cmd.clr_pri) begin
        pri_r <= '0;
      end
      if (cmd.clr_bc) begin
        burst_count_r <= '0;
      end
      if (cmd.clr_ioc) begin
        io_count_r <= '0;
      end
      if (cmd.set_first && first_run_r[16]) begin
        first_run_r <= {1'b0, now_tick - arrival_r};
      end
    end
  end

  assign view.status      = status_r;
  assign view.arrival     = arrival_r;
  assign view.total       = total_r;
  assign view.executed    = executed_r;
  assign view.burst_len   = burst_len_r;
  assign view.burst_count = burst_count_r;
  assign view.io_len      = io_len_r;
  assign view.io_count    = io_count_r;
  assign view.priority_v  = pri_r;
  assign view.first_run   = first_run_r;

endmodule
